### rtl/bucnt_pkg.sv
// Shared types and constants for the block update counter unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bucnt_pkg;

   localparam int CNT_W      = 16;   // stored counter width
   localparam int FIELD_W    = 6;    // row / column field width
   localparam int COUNT_W    = 15;   // update count and threshold width
   localparam int IDX_W      = 9;    // compare width, holds any index up to 256
   localparam int REQ_DATA_W = 40;   // 39 payload bits padded to bytes
   localparam int RSP_DATA_W = 8;

   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 15'd10;
   localparam logic [CNT_W-1:0]   COUNTER_MAX     = '1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_HOLD
   } state_type;

   // read request and operands for the counter read-modify-write
   typedef struct packed {
      logic               rd_en;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] threshold;
   } rmw_req_type;

   typedef struct packed {
      logic clear_busy;
      logic hit;
   } rmw_status_type;

endpackage

### rtl/bucnt_table.sv
// Counter table: one synchronous RAM, post-reset clearing sweep and the
// add / saturate / threshold write-back stage. Depends on bucnt_pkg.
`timescale 1ns / 1ps

module bucnt_table
   import bucnt_pkg::*;
#(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  rmw_req_type       rmw_req,
   input  logic [ADDR_W-1:0] rd_addr,
   output rmw_status_type    rmw_status
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [CNT_W-1:0]   mem_ram [DEPTH];
   logic [CNT_W-1:0]   rd_data_ff;
   logic               s1_valid_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [COUNT_W-1:0] s1_count_ff;
   logic               clr_busy_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   logic [CNT_W:0]     sum_wide;
   logic [CNT_W-1:0]   sum_sat;
   logic               trip;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [CNT_W-1:0]   wr_data;

   // clearing sweep, one entry per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == {ADDR_W{1'b1}}) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rmw_req.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rmw_req.rd_en) begin
         rd_data_ff  <= mem_ram[rd_addr];
         s1_addr_ff  <= rd_addr;
         s1_count_ff <= rmw_req.count;
      end
   end

   always_comb begin
      sum_wide = {1'b0, rd_data_ff} + {{(CNT_W+1-COUNT_W){1'b0}}, s1_count_ff};
      sum_sat  = sum_wide[CNT_W] ? COUNTER_MAX : sum_wide[CNT_W-1:0];
      trip     = sum_sat > {{(CNT_W-COUNT_W){1'b0}}, rmw_req.threshold};
      wr_en    = clr_busy_ff | s1_valid_ff;
      wr_addr  = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
      wr_data  = (clr_busy_ff | trip) ? '0 : sum_sat;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
   end

   assign rmw_status.clear_busy = clr_busy_ff;
   assign rmw_status.hit        = s1_valid_ff & trip;

endmodule

### rtl/block_update_count_trigger_unit.sv
// Block update counter with verification trigger, top level.
// Depends on bucnt_pkg and bucnt_table.
//
// req_* : one beat names an inclusive rectangle of blocks and an update count;
//         every counter inside the table's bounds gets the count added, and a
//         counter that ends above the threshold is cleared and flags the beat.
// rsp_* : one beat per request, bit 0 = verify needed.
// csr_* : threshold, write only, reset value 10; write only with nothing in flight.
// Timing: one counter read-modify-write per cycle on the RAM port. For a
//   request the unit walks every block in the rectangle, flushes the last
//   write-back and loads the result register, then reopens the input; an
//   empty rectangle goes from the accept straight to the flush.
// Reset: the RAM is swept to zero, one entry per cycle, all 2**(ROW_W+COL_W)
//   entries (4096 at 64 x 64); req_tready rises once the state leaves ST_CLEAR.
//   csr writes are taken as usual.
// Stalls: the result sits in an output register and a new request is taken
//   while it waits. A second result ready before the first is taken is held
//   and the input stays closed until rsp_tready.
`timescale 1ns / 1ps

module block_update_count_trigger_unit
   import bucnt_pkg::*;
#(
   parameter int BLOCK_ROWS = 64,
   parameter int BLOCK_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // row_first[5:0], row_last[11:6], col_first[17:12], col_last[23:18],
   // update_count[38:24], zero pad[39]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // verify_needed[0], zero pad[7:1]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data
);

   localparam int ROW_W  = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
   localparam int COL_W  = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam logic [IDX_W-1:0] ROW_MAX = IDX_W'(BLOCK_ROWS - 1);
   localparam logic [IDX_W-1:0] COL_MAX = IDX_W'(BLOCK_COLS - 1);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] threshold_ff;
   logic [ROW_W-1:0]   row_first_ff, row_last_ff, row_ff, row_in;
   logic [COL_W-1:0]   col_last_ff, col_ff, col_in;
   logic [COUNT_W-1:0] count_ff;
   logic               trip_ff, trip_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               rsp_verify_ff, rsp_verify_in;

   logic [FIELD_W-1:0] req_row_first, req_row_last, req_col_first, req_col_last;
   logic [COUNT_W-1:0] req_update_count;
   logic [IDX_W-1:0]   r0_x, r1_x, c0_x, c1_x;
   logic               rect_empty;
   logic               accept;
   logic               rsp_free;
   logic               rsp_load;

   rmw_req_type        rmw_req;
   rmw_status_type     rmw_status;

   assign req_row_first    = req_tdata[5:0];
   assign req_row_last     = req_tdata[11:6];
   assign req_col_first    = req_tdata[17:12];
   assign req_col_last     = req_tdata[23:18];
   assign req_update_count = req_tdata[38:24];

   // clip the rectangle to the table, then test for empty
   always_comb begin
      r0_x = IDX_W'(req_row_first);
      c0_x = IDX_W'(req_col_first);
      r1_x = (IDX_W'(req_row_last) > ROW_MAX) ? ROW_MAX : IDX_W'(req_row_last);
      c1_x = (IDX_W'(req_col_last) > COL_MAX) ? COL_MAX : IDX_W'(req_col_last);
      rect_empty = (r0_x > r1_x) || (c0_x > c1_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, walk counters, trip accumulation and result hand-off
   always_comb begin
      state_in          = state_ff;
      row_in            = row_ff;
      col_in            = col_ff;
      trip_in           = trip_ff | rmw_status.hit;
      req_tready        = 1'b0;
      rmw_req.rd_en     = 1'b0;
      rmw_req.count     = count_ff;
      rmw_req.threshold = threshold_ff;
      rsp_free          = ~rsp_tvalid_ff | rsp_tready;
      rsp_load          = 1'b0;
      rsp_verify_in     = trip_ff | rmw_status.hit;
      accept            = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            if (!rmw_status.clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (req_tvalid) begin
               row_in   = ROW_W'(r0_x);
               col_in   = COL_W'(c0_x);
               trip_in  = 1'b0;
               state_in = rect_empty ? ST_FLUSH : ST_WALK;
            end
         end
         ST_WALK: begin
            rmw_req.rd_en = 1'b1;
            if (row_ff == row_last_ff) begin
               row_in = row_first_ff;
               if (col_ff == col_last_ff) begin
                  state_in = ST_FLUSH;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            // last write-back lands this cycle
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid_in = rsp_load | (rsp_tvalid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_first_ff <= ROW_W'(r0_x);
         row_last_ff  <= ROW_W'(r1_x);
         col_last_ff  <= COL_W'(c1_x);
         count_ff     <= req_update_count;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      trip_ff <= trip_in;
      if (rsp_load) begin
         rsp_verify_ff <= rsp_verify_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   bucnt_table #(
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rmw_req    (rmw_req),
      .rd_addr    ({col_ff, row_ff}),
      .rmw_status (rmw_status)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_verify_ff};

endmodule

### rtl/bucnt_check.sv
// Port-level checks for the block update counter unit, bound to the top.
// Depends on bucnt_pkg and block_update_count_trigger_unit.
`timescale 1ns / 1ps

module bucnt_check
   import bucnt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // one request at a time: not ready right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in flight");

   // RAM clearing sweep keeps the input closed after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input open during clearing sweep");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:1] == '0)
      else $error("rsp padding bits not zero");

endmodule

bind block_update_count_trigger_unit bucnt_check u_bucnt_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

### tb/block_update_count_trigger_unit_tb.sv
// Self-checking testbench for block_update_count_trigger_unit: rectangle updates
// are checked against a per-block tally kept in a small scoreboard class.
// Depends on bucnt_pkg and the unit itself; needs no files or arguments.
`timescale 1ns / 1ps

module block_update_count_trigger_unit_tb;
   import bucnt_pkg::*;

   localparam int ROWS        = 64;
   localparam int COLS        = 64;
   localparam int CYCLE_LIMIT = 1_000_000;  // generous; a correct run needs far fewer
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 235;
   localparam int LONG_HOLD   = 300;        // long receiver hold-off, in cycles
   localparam int TAIL_CYCLES = 20;

   // one request beat, fields as the unit sees them
   typedef struct packed {
      logic [FIELD_W-1:0] row_first;
      logic [FIELD_W-1:0] row_last;
      logic [FIELD_W-1:0] col_first;
      logic [FIELD_W-1:0] col_last;
      logic [COUNT_W-1:0] update_count;
   } rect_update_type;

   // Keeps its own copy of every block tally and the threshold, and queues
   // the verify flag that each accepted request beat should produce.
   class block_tally_board;
      logic [CNT_W-1:0]   tally [ROWS][COLS];
      logic [COUNT_W-1:0] threshold;
      bit                 flags_due [$];
      int                 errors;
      int                 checked;
      int                 flags_set;

      function new();
         foreach (tally[r, c]) tally[r][c] = '0;
         threshold = THRESHOLD_RESET;
         errors    = 0;
         checked   = 0;
         flags_set = 0;
      endfunction

      function void set_threshold(logic [COUNT_W-1:0] value);
         threshold = value;
      endfunction

      function void note_update(rect_update_type u);
         int r_hi, c_hi, r, c, sum;
         bit tripped;
         r_hi = u.row_last;
         c_hi = u.col_last;
         if (r_hi >= ROWS) r_hi = ROWS - 1;
         if (c_hi >= COLS) c_hi = COLS - 1;
         tripped = 1'b0;
         // empty rectangles never reach the loop body
         for (c = u.col_first; c <= c_hi; c++) begin
            for (r = u.row_first; r <= r_hi; r++) begin
               sum = tally[r][c] + u.update_count;
               if (sum > COUNTER_MAX) sum = COUNTER_MAX;
               if (sum > threshold) begin
                  tripped = 1'b1;
                  sum     = 0;
               end
               tally[r][c] = sum[CNT_W-1:0];
            end
         end
         flags_due.push_back(tripped);
      endfunction

      function void check_flag(logic [RSP_DATA_W-1:0] data);
         bit due;
         checked++;
         if (data[0]) flags_set++;
         if (flags_due.size() == 0) begin
            $display("%0t: result beat with nothing due, verify_needed %0b", $time, data[0]);
            errors++;
         end else begin
            due = flags_due.pop_front();
            if (data[0] !== due) begin
               $display("%0t: verify_needed mismatch, expected %0b, actual %0b",
                        $time, due, data[0]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return flags_due.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;

   block_tally_board board = new();

   bit idle_on     = 1'b1;  // random idling allowed in this stretch
   bit calm        = 1'b0;  // closing part of the run: no idling at all
   bit hold_asked  = 1'b0;  // sender asks the receiver for one long hold-off
   int cycle_count = 0;
   int beats_sent  = 0;
   int settings    = 0;

   block_update_count_trigger_unit #(
      .BLOCK_ROWS (ROWS),
      .BLOCK_COLS (COLS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Run limit. Covers the clearing sweep after reset, the full-table beats
   // and the long hold-off many times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached, %0d flags still due",
                  $time, CYCLE_LIMIT, board.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: every accepted beat is checked against the oldest flag due.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_flag(rsp_tdata);
   end

   // Receiver: ready most of the time, random stall bursts, and one long
   // hold-off on request so the output register and the held result fill and
   // the unit has to stall its input.
   initial begin
      forever begin
         if (hold_asked) begin
            hold_asked = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic rect_update_type mk_update(int rf, int rl, int cf, int cl, int cnt);
      rect_update_type u;
      u.row_first    = FIELD_W'(rf);
      u.row_last     = FIELD_W'(rl);
      u.col_first    = FIELD_W'(cf);
      u.col_last     = FIELD_W'(cl);
      u.update_count = COUNT_W'(cnt);
      return u;
   endfunction

   // Mostly small panels of up to sixteen blocks, some strips, some empty
   // rectangles as noise, a few unconstrained ones and now and then the
   // whole table. Counts are weighted around the current threshold.
   function automatic rect_update_type random_update(int thr);
      int sel, kind, rf, rl, cf, cl, cnt, lo, hi;
      sel = $urandom_range(0, 99);
      rf  = $urandom_range(0, ROWS - 1);
      cf  = $urandom_range(0, COLS - 1);
      if (sel < 75) begin
         rl = rf + $urandom_range(0, 3);
         cl = cf + $urandom_range(0, 3);
      end else if (sel < 85) begin
         if ($urandom_range(0, 1)) begin
            rl = rf;
            cl = cf + $urandom_range(0, 15);
         end else begin
            rl = rf + $urandom_range(0, 15);
            cl = cf;
         end
      end else if (sel < 93) begin
         // empty in rows, columns or both
         kind = $urandom_range(0, 2);
         rl   = rf + $urandom_range(0, 3);
         cl   = cf + $urandom_range(0, 3);
         if (kind != 1) begin
            rl = $urandom_range(0, ROWS - 2);
            rf = $urandom_range(rl + 1, ROWS - 1);
         end
         if (kind != 0) begin
            cl = $urandom_range(0, COLS - 2);
            cf = $urandom_range(cl + 1, COLS - 1);
         end
      end else if (sel < 99) begin
         rl = $urandom_range(0, ROWS - 1);
         cl = $urandom_range(0, COLS - 1);
      end else begin
         rf = 0;
         rl = ROWS - 1;
         cf = 0;
         cl = COLS - 1;
      end
      if (rl > ROWS - 1) rl = ROWS - 1;
      if (cl > COLS - 1) cl = COLS - 1;

      kind = $urandom_range(0, 9);
      lo   = (thr > 2) ? thr - 2 : 0;
      hi   = (thr < 32766) ? thr + 1 : 32767;
      case (kind)
         0:       cnt = 0;
         1, 2:    cnt = $urandom_range(0, 32767);
         7, 8:    cnt = $urandom_range(lo, hi);
         9:       cnt = 32767;
         default: cnt = $urandom_range(0, thr / 4);
      endcase
      return mk_update(rf, rl, cf, cl, cnt);
   endfunction

   // One request beat. tvalid stays high on return so the next beat can
   // follow back to back; gaps and drains lower it.
   task automatic send_update(input rect_update_type u);
      req_tdata  <= {1'b0, u.update_count, u.col_last, u.col_first, u.row_last, u.row_first};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_update(u);
      beats_sent++;
   endtask

   task automatic sender_gap();
      if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every flag due has come back, plus a few
   // cycles for the walk to settle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Threshold writes only ever happen with the unit idle.
   task automatic write_threshold(input int value);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_threshold(COUNT_W'(value));
      settings++;
   endtask

   task automatic random_phase(input int phase);
      int i;
      for (i = 0; i < PHASE_BEATS; i++) begin
         if (!calm && i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 2 && i == 60) begin
            idle_on    = 1'b0;
            hold_asked = 1'b1;  // sender keeps offering throughout
         end
         if (phase == 4 && i == 100) wait_drain();
         send_update(random_update(board.threshold));
         sender_gap();
      end
   endtask

   initial begin
      int phase, thr;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset threshold of 10 first. Beats wait out
      // the clearing sweep on req_tready.
      send_update(mk_update(0, 0, 0, 0, 5));          // below threshold
      send_update(mk_update(0, 0, 0, 0, 6));          // 11 > 10, trips
      send_update(mk_update(63, 63, 63, 63, 10));     // equal is not above
      send_update(mk_update(63, 63, 63, 63, 1));
      send_update(mk_update(0, 63, 0, 63, 32767));    // whole table, largest count
      send_update(mk_update(5, 4, 0, 63, 100));       // empty in rows
      send_update(mk_update(0, 63, 40, 39, 100));     // empty in columns
      send_update(mk_update(63, 0, 63, 0, 32767));    // empty in both
      send_update(mk_update(0, 63, 31, 31, 0));       // zero count, column strip
      send_update(mk_update(17, 17, 0, 63, 7));       // row strip
      send_update(mk_update(17, 17, 0, 63, 4));

      // largest threshold: a counter at 32767 only trips on the next beat
      write_threshold(32767);
      send_update(mk_update(42, 42, 21, 21, 32767));
      send_update(mk_update(42, 42, 21, 21, 32767));

      // zero threshold: any non-zero count trips
      write_threshold(0);
      send_update(mk_update(10, 12, 10, 12, 0));
      send_update(mk_update(10, 12, 10, 12, 1));

      // lowered threshold: counters sitting at 1000 trip on a zero-count beat
      write_threshold(1000);
      send_update(mk_update(30, 33, 30, 33, 500));
      send_update(mk_update(30, 33, 30, 33, 500));
      write_threshold(100);
      send_update(mk_update(30, 30, 30, 30, 0));
      send_update(mk_update(30, 33, 30, 33, 0));

      // alternating bit patterns in the count field
      send_update(mk_update(21, 42, 5, 58, 15'h2AAA));
      send_update(mk_update(42, 53, 58, 63, 15'h5555));

      // Random part, one threshold setting per phase; the last phase runs
      // with both sides flat out.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       thr = 32767;
            1:       thr = 0;
            2:       thr = $urandom_range(1, 63);
            3:       thr = THRESHOLD_RESET;
            5:       thr = $urandom_range(100, 2000);
            7:       thr = $urandom_range(1, 40);
            default: thr = $urandom_range(0, 32767);
         endcase
         write_threshold(thr);
         calm    = (phase == PHASES - 1);
         idle_on = !calm;
         random_phase(phase);
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.pending() != 0) begin
         $display("%0t: %0d flags never arrived", $time, board.pending());
         board.errors++;
      end

      $display("Sent %0d update beats over %0d threshold settings (0 and 32767 among them),",
               beats_sent, settings + 1);
      $display("checked %0d result beats, %0d with verify_needed set, %0d errors.",
               board.checked, board.flags_set, board.errors);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
